// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define IRAV_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IRAV_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/irav_pkg.sv
// Shared types and constants of the interval running average block.
`default_nettype none

package irav_pkg;

  localparam int CFG_W    = 7;
  localparam int TIME_W   = 32;
  localparam int WSIZE_RST = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIV,
    S_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic update;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: src/interval_running_average.sv
// Interval running average: mean of the last mark-to-mark intervals.
//
// Input channel (in_valid/in_ready, mark_time_ms) takes one mark request
// at a time; every mark yields one result request on the output channel
// (out_valid/out_ready, average_ms, sample_count, window_full).
// The first mark after reset only records its timestamp. Later marks
// store the wrapped interval in a ring sized by the window register.
// A mark with a stored interval passes through READ, UPDATE, DIV,
// WAIT and OUT; the first mark skips READ and UPDATE. The bit-serial
// divider, one quotient bit per cycle over the running sum, works in
// WAIT. in_ready rises again when the result enters the output
// register. If the receiver stalls, the finished result waits in the
// controller until the output register frees, and the next mark is
// not taken. Reset is synchronous: the window size returns to 8 and
// the ring, sum, timestamp and flags clear; ring contents need no
// clearing. cfg_we writes the window size and empties the ring; the
// user must use it only while idle, which the block does not enforce.
`default_nettype none

module interval_running_average #(
  parameter int WINDOW_MAX = 64,
  localparam int CW = $clog2(WINDOW_MAX + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [irav_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [irav_pkg::TIME_W-1:0] mark_time_ms,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [irav_pkg::TIME_W-1:0]      average_ms,
  output logic [CW-1:0]                    sample_count,
  output logic                             window_full
);

  irav_pkg::cmd_t    cmd;
  irav_pkg::status_t status;

  irav_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  irav_datapath #(
    .WINDOW_MAX(WINDOW_MAX),
    .CW        (CW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mark_time_ms (mark_time_ms),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .average_ms   (average_ms),
    .sample_count (sample_count),
    .window_full  (window_full)
  );

endmodule

`default_nettype wire

// File: src/irav_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module irav_div #(
  parameter int DW = 38,
  parameter int VW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int NW = $clog2(DW + 1);

  logic          busy;
  logic [NW-1:0] step;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [VW:0]   trial;
  logic          ge;

  always_comb begin
    trial = {rem, quotient[DW-1]};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + NW'(1);
        if (step == NW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= ge ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
      quotient <= {quotient[DW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: src/irav_datapath.sv
// Datapath: interval ring, running sum, divider and result register.
`default_nettype none

module irav_datapath #(
  parameter int WINDOW_MAX = 64,
  parameter int CW         = 7
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [irav_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic [irav_pkg::TIME_W-1:0]  mark_time_ms,
  input  wire irav_pkg::cmd_t               cmd,
  output irav_pkg::status_t                 status,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [irav_pkg::TIME_W-1:0]       average_ms,
  output logic [CW-1:0]                     sample_count,
  output logic                              window_full
);

  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SW = irav_pkg::TIME_W + PW;
  localparam int EW = (CW > irav_pkg::CFG_W) ? CW : irav_pkg::CFG_W;
  localparam int TW = irav_pkg::TIME_W;

  logic [irav_pkg::CFG_W-1:0] win_size;
  logic [PW-1:0]              write_position;
  logic                       full_flag;
  logic                       started_flag;
  logic [TW-1:0]              last_mark_time;
  logic [SW-1:0]              running_sum;
  logic [TW-1:0]              now_q;
  logic [TW-1:0]              rd_data;
  logic [CW-1:0]              count_q;
  logic [TW-1:0]              mem [WINDOW_MAX];

  logic [EW-1:0] wsz_ext;
  logic [CW-1:0] weff;
  logic [CW-1:0] wp_ext;
  logic [PW-1:0] pos;
  logic [CW-1:0] pos_inc;
  logic          wrap;
  logic [PW-1:0] pos_next;
  logic [TW-1:0] interval;
  logic [TW-1:0] old_val;
  logic [SW-1:0] sum_next;
  logic [CW-1:0] count;
  logic          div_done;
  logic [SW-1:0] quotient;

  always_comb begin
    wsz_ext = EW'(win_size);
    if (wsz_ext == '0) begin
      weff = CW'(1);
    end else if (wsz_ext > EW'(WINDOW_MAX)) begin
      weff = CW'(WINDOW_MAX);
    end else begin
      weff = CW'(wsz_ext);
    end
    wp_ext   = CW'(write_position);
    pos      = (wp_ext >= weff) ? '0 : write_position;
    pos_inc  = CW'(pos) + CW'(1);
    wrap     = pos_inc >= weff;
    pos_next = wrap ? '0 : pos_inc[PW-1:0];
    interval = now_q - last_mark_time;
    old_val  = full_flag ? rd_data : '0;
    sum_next = running_sum + SW'(interval) - SW'(old_val);
    count    = full_flag ? weff : wp_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size       <= irav_pkg::CFG_W'(irav_pkg::WSIZE_RST);
      write_position <= '0;
      full_flag      <= 1'b0;
      started_flag   <= 1'b0;
      last_mark_time <= '0;
      running_sum    <= '0;
    end else begin
      if (cfg_we) begin
        win_size       <= cfg_wdata;
        write_position <= '0;
        full_flag      <= 1'b0;
        running_sum    <= '0;
      end else if (cmd.update) begin
        write_position <= pos_next;
        running_sum    <= sum_next;
        last_mark_time <= now_q;
        if (wrap) begin
          full_flag <= 1'b1;
        end
      end
      if (cmd.capture && !started_flag) begin
        started_flag   <= 1'b1;
        last_mark_time <= mark_time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_q <= mark_time_ms;
    end
    if (cmd.div_start) begin
      count_q <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mem[pos] <= interval;
    end
    if (cmd.read) begin
      rd_data <= mem[pos];
    end
  end

  irav_div #(
    .DW(SW),
    .VW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (running_sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average_ms   <= (count_q == '0) ? '0 : quotient[TW-1:0];
      sample_count <= count_q;
      window_full  <= full_flag;
    end
  end

  always_comb begin
    status.started  = started_flag;
    status.div_done = div_done;
    status.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// File: src/irav_ctrl.sv
// Controller state machine sequencing one mark through the datapath.
`default_nettype none

module irav_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire irav_pkg::status_t status,
  output irav_pkg::cmd_t         cmd
);

  irav_pkg::state_t state;
  irav_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irav_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      irav_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = status.started ? irav_pkg::S_READ : irav_pkg::S_DIV;
        end
      end
      irav_pkg::S_READ: begin
        cmd.read   = 1'b1;
        state_next = irav_pkg::S_UPDATE;
      end
      irav_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = irav_pkg::S_DIV;
      end
      irav_pkg::S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = irav_pkg::S_WAIT;
      end
      irav_pkg::S_WAIT: begin
        if (status.div_done) begin
          state_next = irav_pkg::S_OUT;
        end
      end
      irav_pkg::S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = irav_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = irav_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/irav_checker.sv
// Port-level checker for the interval running average block, with bind.
`default_nettype none
`include "assert_macros.svh"

module irav_checker #(
  parameter int WINDOW_MAX = 64,
  localparam int CW = $clog2(WINDOW_MAX + 1)
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [irav_pkg::TIME_W-1:0] average_ms,
  input wire logic [CW-1:0]               sample_count,
  input wire logic                        window_full
);

  `IRAV_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(average_ms) && $stable(sample_count) && $stable(window_full), "stalled result changed")
  `IRAV_ASSERT(a_one_at_a_time, clk, rst, in_valid && in_ready |=> !in_ready, "second mark taken while busy")
  `IRAV_ASSERT(a_count_range, clk, rst, out_valid |-> sample_count <= CW'(WINDOW_MAX), "sample count beyond window")
  `IRAV_ASSERT(a_empty_zero, clk, rst, out_valid && sample_count == '0 |-> average_ms == '0 && !window_full, "empty window gave nonzero result")
  `IRAV_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !out_valid, "result present after reset")

endmodule

bind interval_running_average irav_checker #(.WINDOW_MAX(WINDOW_MAX)) u_irav_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .average_ms   (average_ms),
  .sample_count (sample_count),
  .window_full  (window_full)
);

`default_nettype wire

// File: test/testbench.sv
// Testbench for interval_running_average: directed table, then random mark phases.
`default_nettype none

module testbench;

  localparam int WMAX  = 64;
  localparam int CW    = $clog2(WMAX + 1);
  localparam int TW    = irav_pkg::TIME_W;
  localparam int LIMIT = 500000;
  localparam int N_RAND = 532;

  typedef struct packed {
    logic [TW-1:0] average_ms;
    logic [CW-1:0] count;
    logic          full;
  } avg_result_t;

  typedef struct packed {
    logic                      is_cfg;
    logic [irav_pkg::CFG_W-1:0] cfg;
    logic [TW-1:0]             t;
    logic                      typed;
    avg_result_t               res;
  } dir_row_t;

  typedef enum int {GAP_SMALL, GAP_ZERO, GAP_MAX, GAP_HUGE, GAP_ANY} gap_e;
  typedef enum int {ST_MIXED, ST_SHORT, ST_LONG, ST_RANDOM} mix_e;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [irav_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  wire                        in_ready;
  logic [TW-1:0]              mark_time_ms = '0;
  wire                        out_valid;
  logic                       out_ready = 1'b0;
  wire [TW-1:0]               average_ms;
  wire [CW-1:0]               sample_count;
  wire                        window_full;

  // interval ring mirror
  logic [TW-1:0]              ring [WMAX];
  logic [5:0]                 wr_pos = '0;
  logic                       ring_full = 1'b0;
  logic                       started = 1'b0;
  logic [TW-1:0]              last_time = '0;
  logic [37:0]                ring_sum = '0;
  logic [irav_pkg::CFG_W-1:0] win_cfg = 7'd8;

  avg_result_t avg_expect_q [$];
  dir_row_t    dir_tab [$];
  avg_result_t got_exp;
  logic [TW-1:0] last_sent = '0;
  int err_count = 0;
  int cycle_count = 0;
  int sent_n = 0;
  int send_pct = 0;
  int recv_pct = 0;

  interval_running_average #(.WINDOW_MAX(WMAX)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mark_time_ms (mark_time_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .average_ms   (average_ms),
    .sample_count (sample_count),
    .window_full  (window_full)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic avg_result_t predict_average(input logic [TW-1:0] now);
    int unsigned w;
    int unsigned pos;
    int unsigned cnt;
    logic [TW-1:0] gap;
    avg_result_t r;
    w = win_cfg;
    if (w == 0) w = 1;
    if (w > WMAX) w = WMAX;
    if (!started) begin
      started = 1'b1;
      last_time = now;
    end else begin
      gap = now - last_time;
      pos = wr_pos;
      if (pos >= w) pos = 0;
      last_time = now;
      if (ring_full) ring_sum = ring_sum - ring[pos];
      ring[pos] = gap;
      ring_sum = ring_sum + gap;
      pos++;
      if (pos >= w) begin
        pos = 0;
        ring_full = 1'b1;
      end
      wr_pos = 6'(pos);
    end
    cnt = ring_full ? w : wr_pos;
    r.count = CW'(cnt);
    r.full = ring_full;
    r.average_ms = (cnt == 0) ? '0 : TW'(ring_sum / cnt);
    return r;
  endfunction

  function automatic logic [TW-1:0] next_time(input mix_e style);
    gap_e kind;
    case (style)
      ST_SHORT: kind = ($urandom_range(0, 9) == 0) ? GAP_ZERO : GAP_SMALL;
      ST_LONG: kind = GAP_MAX;
      ST_RANDOM: kind = GAP_ANY;
      default: kind = gap_e'($urandom_range(0, 4));
    endcase
    case (kind)
      GAP_SMALL: return last_sent + $urandom_range(1, 1000);
      GAP_ZERO: return last_sent;
      GAP_MAX: return last_sent - 1;
      GAP_HUGE: return last_sent + $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_row(input logic is_cfg, input logic [irav_pkg::CFG_W-1:0] cfg,
                                  input logic [TW-1:0] t, input logic typed,
                                  input avg_result_t res);
    dir_row_t row;
    row.is_cfg = is_cfg;
    row.cfg = cfg;
    row.t = t;
    row.typed = typed;
    row.res = res;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  task automatic send_mark(input logic [TW-1:0] t, input logic typed,
                           input avg_result_t typed_res);
    int gap;
    avg_result_t r;
    gap = 0;
    if (sent_n < 190) begin
      send_pct = 23;
      recv_pct = 46;
    end else if (sent_n < 380) begin
      send_pct = 46;
      recv_pct = 23;
    end else begin
      send_pct = 0;
      recv_pct = 0;
    end
    while ($urandom_range(0, 99) < send_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mark_time_ms <= t;
    do @(posedge clk); while (!in_ready);
    r = predict_average(t);
    avg_expect_q.insert(avg_expect_q.size(), typed ? typed_res : r);
    last_sent = t;
    sent_n++;
  endtask

  // drain, then write window size; ring mirror clears, start and timestamp kept
  task automatic load_window(input logic [irav_pkg::CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (avg_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_cfg = v;
    wr_pos = '0;
    ring_full = 1'b0;
    ring_sum = '0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (avg_expect_q.size() == 0) begin
        $display("%0t: result request with none pending, average_ms %0d", $time, average_ms);
        err_count++;
      end else begin
        got_exp = avg_expect_q.pop_front();
        if (average_ms !== got_exp.average_ms) begin
          $display("%0t: average_ms expected %0d actual %0d", $time,
                   got_exp.average_ms, average_ms);
          err_count++;
        end
        if (sample_count !== got_exp.count) begin
          $display("%0t: sample_count expected %0d actual %0d", $time,
                   got_exp.count, sample_count);
          err_count++;
        end
        if (window_full !== got_exp.full) begin
          $display("%0t: window_full expected %0d actual %0d", $time,
                   got_exp.full, window_full);
          err_count++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_pct);
  end

  initial begin
    int phase;
    int len;
    int n_rand;
    logic [irav_pkg::CFG_W-1:0] wv;
    mix_e style;
    avg_result_t none;
    none = '0;
    n_rand = 0;
    phase = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first mark only records time
    add_row(1'b0, '0, 32'd100, 1'b1, '{32'd0, 7'd0, 1'b0});
    add_row(1'b0, '0, 32'hFFFF_FFFF, 1'b0, none);
    add_row(1'b0, '0, 32'd4, 1'b0, none);
    add_row(1'b0, '0, 32'd4, 1'b0, none);
    for (int k = 1; k <= 6; k++) add_row(1'b0, '0, 32'(100 * k), 1'b0, none);
    // size zero acts as one; ring cleared but next mark still stores
    add_row(1'b1, 7'd0, '0, 1'b0, none);
    add_row(1'b0, '0, 32'd0, 1'b0, none);
    add_row(1'b0, '0, 32'd0, 1'b1, '{32'd0, 7'd1, 1'b1});
    // oversize saturates, maximum intervals
    add_row(1'b1, 7'd127, '0, 1'b0, none);
    add_row(1'b0, '0, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 7'd1, 1'b0});
    add_row(1'b0, '0, 32'hFFFF_FFFE, 1'b1, '{32'hFFFF_FFFF, 7'd2, 1'b0});
    add_row(1'b1, 7'd64, '0, 1'b0, none);
    add_row(1'b0, '0, 32'h8000_0000, 1'b0, none);
    add_row(1'b0, '0, 32'h7FFF_FFFF, 1'b0, none);
    add_row(1'b1, 7'd1, '0, 1'b0, none);
    add_row(1'b0, '0, 32'd5, 1'b0, none);
    add_row(1'b0, '0, 32'd9, 1'b1, '{32'd4, 7'd1, 1'b1});

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) load_window(dir_tab[i].cfg);
      else send_mark(dir_tab[i].t, dir_tab[i].typed, dir_tab[i].res);
    end

    while (n_rand < N_RAND) begin
      case (phase)
        0: wv = 7'd64;
        1: wv = 7'd1;
        2: wv = 7'd127;
        3: wv = 7'd0;
        4: wv = 7'd2;
        default: wv = 7'($urandom_range(1, 127));
      endcase
      style = (phase == 0) ? ST_LONG : mix_e'($urandom_range(0, 3));
      len = (wv >= 64) ? $urandom_range(70, 100) : $urandom_range(30, 70);
      if (len > N_RAND - n_rand) len = N_RAND - n_rand;
      load_window(wv);
      repeat (len) begin
        send_mark(next_time(style), 1'b0, none);
        n_rand++;
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (avg_expect_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/irav_pkg.sv
src/irav_div.sv
src/irav_datapath.sv
src/irav_ctrl.sv
src/interval_running_average.sv
src/irav_checker.sv
test/testbench.sv
